// ===== rtl/hrsp_pkg.sv =====
// shared types and constants of the hex record stream parser
package hrsp_pkg;

  // line parse phase, one-hot
  typedef enum logic [6:0] {
    PH_COLON = 7'b0000001,
    PH_COUNT = 7'b0000010,
    PH_ADDR  = 7'b0000100,
    PH_TYPE  = 7'b0001000,
    PH_SEG   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_SKIP  = 7'b1000000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_TENTATIVE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT    = 2'd1;
  localparam logic [1:0] KIND_FMT_ERR   = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd3;

  // record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_END     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;

  // characters
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [20:0] FLASH_SIZE_RESET = 21'h040000;

  // one input character with its file-start flag
  typedef struct packed {
    logic [7:0] ch;
    logic       new_file;
  } item_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] byte_address;
    logic [7:0]  byte_value;
    logic [20:0] highest_address;
  } result_t;

endpackage

// ===== rtl/hex_record_stream_parser.sv =====
// top level of the hex record stream parser
// Takes the text of an Intel HEX file one character per transfer on the in_
// channel (in_new_file restarts addressing and the stop state before that
// character) and gives data bytes, record accepts, format errors and
// overflows on the out_ channel, at most one result per character.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. The flash size is written through cfg_valid/cfg_ready;
// the user must write it only while idle, which the block does not enforce.
// cfg_ready is always high. Throughput: one character per cycle while
// nothing stalls. A character sits in the input register, is parsed by
// combinational logic and its result is loaded into the output register,
// which drives out_valid. When out_stall holds a result, characters that
// make no result keep flowing; one that makes a result waits in the input
// register and then in_stall rises. Synchronous reset empties both
// registers, restarts the line parser with address, highest address and
// stop state cleared, and sets flash size to 262144.
module hex_record_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_new_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [20:0] out_byte_address,
  output logic [7:0]  out_byte_value,
  output logic [20:0] out_highest_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_flash_size
);

  logic              item_valid;
  hrsp_pkg::item_t   item;
  logic              take;
  logic              res_valid;
  hrsp_pkg::result_t res;
  logic              out_free;

  // input register
  hrsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ch      (in_ch),
    .in_new_file(in_new_file),
    .in_stall   (in_stall),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // parser state and logic
  hrsp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .out_free      (out_free),
    .take          (take),
    .res_valid     (res_valid),
    .res           (res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_flash_size(cfg_flash_size)
  );

  // result register
  hrsp_out_stage u_out_stage (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (take && res_valid),
    .res_in             (res),
    .out_free           (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_byte_address   (out_byte_address),
    .out_byte_value     (out_byte_value),
    .out_highest_address(out_highest_address)
  );

  // stall only with a character waiting in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid)
    else $error("input stalled with empty input register");

  // format errors carry no byte
  a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hrsp_pkg::KIND_FMT_ERR)
      |-> (out_byte_address == 21'd0) && (out_byte_value == 8'd0))
    else $error("format error result carries a byte");

  // an accepted record's last byte lies within the highest address
  a_accept_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == hrsp_pkg::KIND_ACCEPT)
      |-> (out_highest_address >= out_byte_address))
    else $error("accepted byte above highest address");

  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid |-> out_free)
    else $error("result loaded into a full output register");

endmodule

// ===== rtl/hrsp_in_stage.sv =====
// input register stage of the hex record stream parser
module hrsp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [7:0]      in_ch,
  input  logic            in_new_file,
  output logic            in_stall,
  input  logic            take,
  output logic            item_valid,
  output hrsp_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  hrsp_pkg::item_t item_r;
  logic            accept;

  // hold off only while a character waits and cannot move on
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.ch       <= in_ch;
      item_r.new_file <= in_new_file;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== rtl/hrsp_core.sv =====
// parse state and per-character logic of the hex record stream parser
module hrsp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  hrsp_pkg::item_t   item,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output hrsp_pkg::result_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [20:0]       cfg_flash_size
);

  hrsp_pkg::phase_t phase_r, phase_nxt, e_phase;
  logic [1:0]  dc_r, dc_nxt, e_dc;
  logic [15:0] acc_r, acc_nxt, e_acc;
  logic [7:0]  len_r, len_nxt, e_len;
  logic [7:0]  bl_r, bl_nxt, e_bl;
  logic [20:0] ra_r, ra_nxt, e_ra;
  logic [20:0] rs_r, rs_nxt, e_rs;
  logic [20:0] max_r, max_nxt, e_max;
  logic        stop_r, stop_nxt, e_stop;
  logic [20:0] flash_r;

  logic        nib_ok;
  logic [3:0]  nib;
  logic [15:0] acc_new;
  logic        need4;
  logic        last_digit;
  logic [7:0]  offs;
  logic [20:0] data_addr;
  logic [21:0] rec_end;
  logic [21:0] end_m1;
  logic        overflow;
  logic [7:0]  bl_dec;

  // flash size; user must write it only while idle, block does not check
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_r <= hrsp_pkg::FLASH_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flash_r <= cfg_flash_size;
    end
  end

  // state as seen by this character, after an optional file restart
  always_comb begin
    if (item.new_file) begin
      e_phase = hrsp_pkg::PH_COLON;
      e_dc    = 2'd0;
      e_acc   = 16'd0;
      e_len   = 8'd0;
      e_bl    = 8'd0;
      e_ra    = 21'd0;
      e_rs    = 21'd0;
      e_max   = 21'd0;
      e_stop  = 1'b0;
    end else begin
      e_phase = phase_r;
      e_dc    = dc_r;
      e_acc   = acc_r;
      e_len   = len_r;
      e_bl    = bl_r;
      e_ra    = ra_r;
      e_rs    = rs_r;
      e_max   = max_r;
      e_stop  = stop_r;
    end
  end

  // hex digit decode, ':' through '?' count as 10 to 15
  always_comb begin
    nib_ok = 1'b0;
    nib    = 4'd0;
    if (item.ch >= 8'h61) begin
      nib_ok = (item.ch <= 8'h66);
      nib    = 4'(item.ch[2:0]) + 4'd9;
    end else if (item.ch >= 8'h41) begin
      nib_ok = (item.ch <= 8'h46);
      nib    = 4'(item.ch[2:0]) + 4'd9;
    end else if (item.ch >= 8'h30) begin
      nib_ok = (item.ch <= 8'h3F);
      nib    = item.ch[3:0];
    end
  end

  assign acc_new    = {e_acc[11:0], nib};
  assign need4      = (e_phase == hrsp_pkg::PH_ADDR) || (e_phase == hrsp_pkg::PH_SEG);
  assign last_digit = need4 ? (e_dc == 2'd3) : (e_dc != 2'd0);

  // data byte address and record end
  assign offs      = e_len - e_bl;
  assign data_addr = e_rs + {13'd0, offs};
  assign rec_end   = {1'b0, e_rs} + {14'd0, e_len};
  assign end_m1    = rec_end - 22'd1;
  assign overflow  = rec_end > {1'b0, flash_r};
  assign bl_dec    = e_bl - 8'd1;

  // next state and result
  always_comb begin
    phase_nxt = e_phase;
    dc_nxt    = e_dc;
    acc_nxt   = e_acc;
    len_nxt   = e_len;
    bl_nxt    = e_bl;
    ra_nxt    = e_ra;
    rs_nxt    = e_rs;
    max_nxt   = e_max;
    stop_nxt  = e_stop;
    res_valid = 1'b0;
    res.kind         = hrsp_pkg::KIND_FMT_ERR;
    res.byte_address = 21'd0;
    res.byte_value   = 8'd0;

    if (!e_stop) begin
      case (e_phase)
        hrsp_pkg::PH_COLON: begin
          if (item.ch != hrsp_pkg::CH_COLON) begin
            stop_nxt  = 1'b1;
            res_valid = 1'b1;
          end else begin
            phase_nxt = hrsp_pkg::PH_COUNT;
            dc_nxt    = 2'd0;
            acc_nxt   = 16'd0;
          end
        end
        hrsp_pkg::PH_SKIP: begin
          if (item.ch == hrsp_pkg::CH_NEWLINE) begin
            phase_nxt = hrsp_pkg::PH_COLON;
          end
        end
        hrsp_pkg::PH_COUNT, hrsp_pkg::PH_ADDR, hrsp_pkg::PH_TYPE,
        hrsp_pkg::PH_SEG, hrsp_pkg::PH_DATA: begin
          if (!nib_ok) begin
            stop_nxt  = 1'b1;
            res_valid = 1'b1;
          end else if (!last_digit) begin
            dc_nxt  = e_dc + 2'd1;
            acc_nxt = acc_new;
          end else begin
            dc_nxt  = 2'd0;
            acc_nxt = 16'd0;
            case (e_phase)
              hrsp_pkg::PH_COUNT: begin
                len_nxt   = acc_new[7:0];
                phase_nxt = hrsp_pkg::PH_ADDR;
              end
              hrsp_pkg::PH_ADDR: begin
                ra_nxt    = {1'b0, e_ra[19:16], acc_new};
                rs_nxt    = {1'b0, e_ra[19:16], acc_new};
                phase_nxt = hrsp_pkg::PH_TYPE;
              end
              hrsp_pkg::PH_TYPE: begin
                if (acc_new[7:0] == hrsp_pkg::REC_SEGMENT) begin
                  phase_nxt = hrsp_pkg::PH_SEG;
                end else if (acc_new[7:0] == hrsp_pkg::REC_END) begin
                  phase_nxt = hrsp_pkg::PH_SKIP;
                end else if (acc_new[7:0] == hrsp_pkg::REC_DATA) begin
                  if (e_len == 8'd0) begin
                    phase_nxt = hrsp_pkg::PH_SKIP;
                  end else begin
                    bl_nxt    = e_len;
                    phase_nxt = hrsp_pkg::PH_DATA;
                  end
                end else begin
                  stop_nxt  = 1'b1;
                  res_valid = 1'b1;
                end
              end
              hrsp_pkg::PH_SEG: begin
                ra_nxt    = {1'b0, acc_new, 4'h0};
                phase_nxt = hrsp_pkg::PH_SKIP;
              end
              default: begin
                // data byte
                bl_nxt           = bl_dec;
                res_valid        = 1'b1;
                res.byte_address = data_addr;
                res.byte_value   = acc_new[7:0];
                if (bl_dec != 8'd0) begin
                  res.kind = hrsp_pkg::KIND_TENTATIVE;
                end else if (overflow) begin
                  stop_nxt = 1'b1;
                  res.kind = hrsp_pkg::KIND_OVERFLOW;
                end else begin
                  if ({1'b0, e_max} < end_m1) begin
                    max_nxt = end_m1[20:0];
                  end
                  ra_nxt    = 21'(rec_end + 22'd1);
                  phase_nxt = hrsp_pkg::PH_SKIP;
                  res.kind  = hrsp_pkg::KIND_ACCEPT;
                end
              end
            endcase
          end
        end
        default: begin
          if (item.ch == hrsp_pkg::CH_NEWLINE) begin
            phase_nxt = hrsp_pkg::PH_COLON;
          end
        end
      endcase
    end
    res.highest_address = max_nxt;
  end

  // a character moves on unless its result would hit a full output register
  assign take = item_valid && (out_free || !res_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hrsp_pkg::PH_COLON;
      dc_r    <= 2'd0;
      acc_r   <= 16'd0;
      len_r   <= 8'd0;
      bl_r    <= 8'd0;
      ra_r    <= 21'd0;
      rs_r    <= 21'd0;
      max_r   <= 21'd0;
      stop_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      bl_r    <= bl_nxt;
      ra_r    <= ra_nxt;
      rs_r    <= rs_nxt;
      max_r   <= max_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

// ===== rtl/hrsp_out_stage.sv =====
// result register stage of the hex record stream parser
module hrsp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hrsp_pkg::result_t res_in,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [20:0]       out_byte_address,
  output logic [7:0]        out_byte_value,
  output logic [20:0]       out_highest_address
);

  logic              valid_r;
  logic              valid_nxt;
  hrsp_pkg::result_t res_r;

  // register can take a new result when empty or draining this cycle
  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid           = valid_r;
  assign out_kind            = res_r.kind;
  assign out_byte_address    = res_r.byte_address;
  assign out_byte_value      = res_r.byte_value;
  assign out_highest_address = res_r.highest_address;

endmodule
